// ===== hdl/rnm_pkg.sv =====
package rnm_pkg;

    // field and state widths
    localparam int TOTAL_W  = 20;
    localparam int RUN_W    = 16;
    localparam int WEIGHT_W = 11;
    localparam int SYM_W    = 8;
    localparam int IDX_W    = 4;

    // default upper bound on the thousands digit
    localparam int MAX_THOUSANDS_DEFAULT = 9;

    // number of greedy steps, M down to I
    localparam int NUM_STEPS = 13;

    // ascii codes of the roman letters
    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;
    localparam logic [SYM_W-1:0] SYM_LOW_A = 8'h61;
    localparam logic [SYM_W-1:0] SYM_LOW_Z = 8'h7A;
    localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;

    // controller to datapath commands
    typedef struct packed {
        logic parse;
        logic finish;
        logic clamp;
        logic emit_step;
    } rnm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic emit_fire;
        logic emit_last;
    } rnm_status_t;

    // weight of one character, case folded, zero for anything else
    function automatic logic [WEIGHT_W-1:0] letter_weight(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] u;
        logic [WEIGHT_W-1:0] w;
        u = c;
        if (c >= SYM_LOW_A && c <= SYM_LOW_Z)
            u = c - CASE_OFFSET;
        unique case (u)
            SYM_I:   w = WEIGHT_W'(1);
            SYM_V:   w = WEIGHT_W'(5);
            SYM_X:   w = WEIGHT_W'(10);
            SYM_L:   w = WEIGHT_W'(50);
            SYM_C:   w = WEIGHT_W'(100);
            SYM_D:   w = WEIGHT_W'(500);
            SYM_M:   w = WEIGHT_W'(1000);
            default: w = '0;
        endcase
        return w;
    endfunction

    // value of each greedy step
    function automatic logic [WEIGHT_W-1:0] step_value(input logic [IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] v;
        unique case (idx)
            4'd0:    v = WEIGHT_W'(1000);
            4'd1:    v = WEIGHT_W'(900);
            4'd2:    v = WEIGHT_W'(500);
            4'd3:    v = WEIGHT_W'(400);
            4'd4:    v = WEIGHT_W'(100);
            4'd5:    v = WEIGHT_W'(90);
            4'd6:    v = WEIGHT_W'(50);
            4'd7:    v = WEIGHT_W'(40);
            4'd8:    v = WEIGHT_W'(10);
            4'd9:    v = WEIGHT_W'(9);
            4'd10:   v = WEIGHT_W'(5);
            4'd11:   v = WEIGHT_W'(4);
            default: v = WEIGHT_W'(1);
        endcase
        return v;
    endfunction

    // leading letter of each greedy step
    function automatic logic [SYM_W-1:0] step_first(input logic [IDX_W-1:0] idx);
        logic [SYM_W-1:0] s;
        unique case (idx)
            4'd0:    s = SYM_M;
            4'd1:    s = SYM_C;
            4'd2:    s = SYM_D;
            4'd3:    s = SYM_C;
            4'd4:    s = SYM_C;
            4'd5:    s = SYM_X;
            4'd6:    s = SYM_L;
            4'd7:    s = SYM_X;
            4'd8:    s = SYM_X;
            4'd9:    s = SYM_I;
            4'd10:   s = SYM_V;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    // trailing letter of the subtractive steps, none otherwise
    function automatic logic [SYM_W-1:0] step_second(input logic [IDX_W-1:0] idx);
        logic [SYM_W-1:0] s;
        unique case (idx)
            4'd1:    s = SYM_M;
            4'd3:    s = SYM_D;
            4'd5:    s = SYM_C;
            4'd7:    s = SYM_L;
            4'd9:    s = SYM_X;
            4'd11:   s = SYM_V;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/rnm_controller.sv =====
module rnm_controller
    import rnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        end_of_numeral,
    output logic        out_valid,
    input  logic        out_ready,
    output rnm_cmd_t    cmd,
    input  rnm_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINISH,
        ST_CLAMP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.parse = in_valid && in_ready_reg;
                if (cmd.parse && end_of_numeral)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_step = !out_valid_reg || out_ready;
                if (cmd.emit_step && status.emit_fire)
                begin
                    out_valid_next = 1'b1;
                    if (status.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_ready_next = (state_next == ST_IDLE);
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/rnm_datapath.sv =====
module rnm_datapath
    import rnm_pkg::*;
#(
    parameter int MAX_THOUSANDS = MAX_THOUSANDS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rnm_cmd_t         cmd,
    output rnm_status_t      status,
    input  logic [SYM_W-1:0] symbol,
    output logic [SYM_W-1:0] out_symbol,
    output logic             last,
    output logic             is_empty,
    output logic             bad_char,
    output logic             clamped
);

    localparam int MAX_VALUE = MAX_THOUSANDS * 1000 + 999;
    localparam int VAL_W     = $clog2(MAX_VALUE + 1);
    localparam logic signed [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_VALUE);
    localparam logic signed [TOTAL_W-1:0] SAT_HI = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] SAT_LO = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_STEPS - 1);

    // parse state
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [RUN_W-1:0]          run_reg, run_next;
    logic [WEIGHT_W-1:0]       prev_reg, prev_next;
    logic                      start_reg, start_next;
    logic                      err_reg, err_next;

    // emission state
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             half_reg, half_next;
    logic             empty_reg, empty_next;
    logic             clamp_reg, clamp_next;
    logic             err_out_reg, err_out_next;

    // result payload
    logic [SYM_W-1:0] sym_out_reg, sym_out_next;
    logic             last_reg, last_next;
    logic             empty_out_reg, empty_out_next;
    logic             bad_out_reg, bad_out_next;
    logic             clamp_out_reg, clamp_out_next;

    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] prev_eff;
    logic                rise, fall;
    logic [RUN_W:0]      run_sum;
    logic [VAL_W-1:0]    cur_step;
    logic [VAL_W-1:0]    rem_sub;
    logic                rem_done;
    logic                hit;
    logic [SYM_W-1:0]    second;

    // saturating add or subtract of the run into the total
    function automatic logic signed [TOTAL_W-1:0] sat_add(
        input logic signed [TOTAL_W-1:0] t,
        input logic [RUN_W-1:0]          r,
        input logic                      neg
    );
        logic signed [TOTAL_W:0] d;
        logic signed [TOTAL_W:0] s;
        d = $signed({{(TOTAL_W-RUN_W+1){1'b0}}, r});
        s = $signed({t[TOTAL_W-1], t}) + (neg ? -d : d);
        if (s[TOTAL_W] != s[TOTAL_W-1])
            return s[TOTAL_W] ? SAT_LO : SAT_HI;
        return s[TOTAL_W-1:0];
    endfunction

    // character weight and rise / fall against the previous one
    assign weight   = letter_weight(symbol);
    assign prev_eff = start_reg ? weight : prev_reg;
    assign rise     = weight > prev_eff;
    assign fall     = weight < prev_eff;
    assign run_sum  = ((rise || fall) ? {1'b0, {RUN_W{1'b0}}} : {1'b0, run_reg})
                      + (RUN_W+1)'(weight);

    // greedy step compare and subtract
    assign cur_step = VAL_W'(step_value(idx_reg));
    assign hit      = rem_reg >= cur_step;
    assign rem_sub  = rem_reg - cur_step;
    assign rem_done = (rem_sub == '0);
    assign second   = step_second(idx_reg);

    assign status.emit_fire = empty_reg || half_reg || hit;
    assign status.emit_last = empty_reg || ((half_reg || (hit && second == SYM_NONE))
                                            && rem_done);

    always_comb
    begin
        total_next     = total_reg;
        run_next       = run_reg;
        prev_next      = prev_reg;
        start_next     = start_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        half_next      = half_reg;
        empty_next     = empty_reg;
        clamp_next     = clamp_reg;
        err_out_next   = err_out_reg;
        sym_out_next   = sym_out_reg;
        last_next      = last_reg;
        empty_out_next = empty_out_reg;
        bad_out_next   = bad_out_reg;
        clamp_out_next = clamp_out_reg;

        // one character of the numeral
        if (cmd.parse)
        begin
            if (weight == '0)
                err_next = 1'b1;
            if (rise || fall)
                total_next = sat_add(total_reg, run_reg, rise);
            run_next   = run_sum[RUN_W] ? {RUN_W{1'b1}} : run_sum[RUN_W-1:0];
            prev_next  = weight;
            start_next = 1'b0;
        end

        // close the pending run
        if (cmd.finish)
            total_next = sat_add(total_reg, run_reg, 1'b0);

        // clamp, load the emitter, clear parse state
        if (cmd.clamp)
        begin
            if (total_reg[TOTAL_W-1])
            begin
                rem_next   = '0;
                clamp_next = 1'b1;
            end
            else if (total_reg > MAX_TOTAL)
            begin
                rem_next   = VAL_W'(MAX_VALUE);
                clamp_next = 1'b1;
            end
            else
            begin
                rem_next   = total_reg[VAL_W-1:0];
                clamp_next = 1'b0;
            end
            empty_next   = (total_reg == '0) || total_reg[TOTAL_W-1];
            err_out_next = err_reg;
            idx_next     = '0;
            half_next    = 1'b0;
            total_next   = '0;
            run_next     = '0;
            prev_next    = '0;
            start_next   = 1'b1;
            err_next     = 1'b0;
        end

        // one greedy step, a letter out when it fires
        if (cmd.emit_step)
        begin
            // numeral flags travel with each item
            if (status.emit_fire)
            begin
                bad_out_next   = err_out_reg;
                clamp_out_next = clamp_reg;
            end
            if (empty_reg)
            begin
                sym_out_next   = SYM_NONE;
                empty_out_next = 1'b1;
                last_next      = 1'b1;
            end
            else if (half_reg)
            begin
                sym_out_next   = second;
                empty_out_next = 1'b0;
                last_next      = rem_done;
                rem_next       = rem_sub;
                half_next      = 1'b0;
            end
            else if (hit)
            begin
                sym_out_next   = step_first(idx_reg);
                empty_out_next = 1'b0;
                if (second != SYM_NONE)
                begin
                    half_next = 1'b1;
                    last_next = 1'b0;
                end
                else
                begin
                    rem_next  = rem_sub;
                    last_next = rem_done;
                end
            end
            else if (idx_reg != LAST_STEP)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // parse and emission state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            run_reg     <= '0;
            prev_reg    <= '0;
            start_reg   <= 1'b1;
            err_reg     <= 1'b0;
            rem_reg     <= '0;
            idx_reg     <= '0;
            half_reg    <= 1'b0;
            empty_reg   <= 1'b0;
            clamp_reg   <= 1'b0;
            err_out_reg <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            run_reg     <= run_next;
            prev_reg    <= prev_next;
            start_reg   <= start_next;
            err_reg     <= err_next;
            rem_reg     <= rem_next;
            idx_reg     <= idx_next;
            half_reg    <= half_next;
            empty_reg   <= empty_next;
            clamp_reg   <= clamp_next;
            err_out_reg <= err_out_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        sym_out_reg   <= sym_out_next;
        last_reg      <= last_next;
        empty_out_reg <= empty_out_next;
        bad_out_reg   <= bad_out_next;
        clamp_out_reg <= clamp_out_next;
    end

    assign out_symbol = sym_out_reg;
    assign last       = last_reg;
    assign is_empty   = empty_out_reg;
    assign bad_char   = bad_out_reg;
    assign clamped    = clamp_out_reg;

endmodule

// ===== hdl/roman_numeral_minimizer.sv =====
// a character that does not end a numeral is taken in one cycle, back to back
// on the final character: finish state closes the run, clamp state clamps, then the
// greedy emitter walks the steps from M down to I, giving their letters (13 steps at most)
// results leave through an output register paced by out_ready; input waits meanwhile
// reset: asynchronous, active low; parse state cleared, no result pending
module roman_numeral_minimizer
    import rnm_pkg::*;
#(
    parameter int MAX_THOUSANDS = MAX_THOUSANDS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SYM_W-1:0] symbol,
    input  logic             end_of_numeral,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SYM_W-1:0] out_symbol,
    output logic             last,
    output logic             is_empty,
    output logic             bad_char,
    output logic             clamped
);

    rnm_cmd_t    cmd;
    rnm_status_t status;

    // sequencing
    rnm_controller u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .end_of_numeral (end_of_numeral),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .status         (status)
    );

    // parse, clamp and greedy emission
    rnm_datapath #(
        .MAX_THOUSANDS (MAX_THOUSANDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .symbol     (symbol),
        .out_symbol (out_symbol),
        .last       (last),
        .is_empty   (is_empty),
        .bad_char   (bad_char),
        .clamped    (clamped)
    );

`ifndef NO_ASSERTIONS
    // an empty numeral is a single item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> last)
        else $error("empty result without last");

    // a non-empty item carries a roman letter
    a_letter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_empty |-> (out_symbol == SYM_I || out_symbol == SYM_V ||
            out_symbol == SYM_X || out_symbol == SYM_L || out_symbol == SYM_C ||
            out_symbol == SYM_D || out_symbol == SYM_M))
        else $error("result symbol is not a roman letter");

    // no input taken while emitting
    a_no_parse_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> !in_ready)
        else $error("input ready during emission");

    // input reopens right after the last letter
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step && status.emit_fire && status.emit_last |=> in_ready && out_valid && last)
        else $error("input not reopened after last item");
`endif

endmodule

// ===== test/roman_numeral_minimizer_tb.sv =====
`timescale 1ns / 100ps

module roman_numeral_minimizer_tb;

    import rnm_pkg::*;

    localparam int MAX_VALUE    = MAX_THOUSANDS_DEFAULT * 1000 + 999;
    localparam int TOTAL_HI     = 2 ** (TOTAL_W - 1) - 1;
    localparam int TOTAL_LO     = -(2 ** (TOTAL_W - 1));
    localparam int RUN_HI       = 2 ** RUN_W - 1;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 50;

    // one emitted letter as the block should present it
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             empty;
        logic             bad;
        logic             clamp;
    } letter_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [SYM_W-1:0] symbol = '0;
    logic             end_of_numeral = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [SYM_W-1:0] out_symbol;
    logic             last;
    logic             is_empty;
    logic             bad_char;
    logic             clamped;

    // greedy steps of the minimal form
    int               step_val  [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    logic [SYM_W-1:0] step_lead [13] = '{SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
                                         SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I};
    logic [SYM_W-1:0] step_trail[13] = '{SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C,
                                         SYM_NONE, SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V,
                                         SYM_NONE};
    logic [SYM_W-1:0] roman_set [7]  = '{SYM_I, SYM_V, SYM_X, SYM_L, SYM_C, SYM_D, SYM_M};

    // parse state of the numeral being received
    int               total_acc;
    int               run_acc;
    int               prev_weight;
    bit               first_char;
    bit               saw_bad;

    letter_t          minimal_letters[$];
    logic [SYM_W-1:0] spelled[$];
    int               mismatches;
    int               chars_sent;
    int               burst_left;
    int               idle_cycles;
    int               ready_mode;
    int               ready_phase_left;
    int               ready_tick;

    roman_numeral_minimizer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol         (symbol),
        .end_of_numeral (end_of_numeral),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_symbol     (out_symbol),
        .last           (last),
        .is_empty       (is_empty),
        .bad_char       (bad_char),
        .clamped        (clamped)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // weight of one character, letters folded to upper case
    function automatic int char_weight(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] up;
        up = c;
        if (c >= SYM_LOW_A && c <= SYM_LOW_Z)
            up = c - CASE_OFFSET;
        case (up)
            SYM_I:   return 1;
            SYM_V:   return 5;
            SYM_X:   return 10;
            SYM_L:   return 50;
            SYM_C:   return 100;
            SYM_D:   return 500;
            SYM_M:   return 1000;
            default: return 0;
        endcase
    endfunction

    // saturating update of the numeral total
    function automatic void total_add(input int delta);
        int t;
        t = total_acc + delta;
        if (t > TOTAL_HI)
            t = TOTAL_HI;
        if (t < TOTAL_LO)
            t = TOTAL_LO;
        total_acc = t;
    endfunction

    // minimal greedy spelling of a value into spelled
    function automatic void spell_minimal(input int value);
        int rest;
        rest = value;
        spelled.delete();
        for (int i = 0; i < 13; i++)
        begin
            while (rest >= step_val[i])
            begin
                spelled.push_back(step_lead[i]);
                if (step_trail[i] != SYM_NONE)
                    spelled.push_back(step_trail[i]);
                rest -= step_val[i];
            end
        end
    endfunction

    // fold one accepted character into the numeral, queue letters on the final one
    function automatic void parse_char(input logic [SYM_W-1:0] sym, input logic eon);
        int      w;
        int      value;
        logic    clamp;
        letter_t item;
        w = char_weight(sym);
        if (w == 0)
            saw_bad = 1'b1;
        if (first_char)
        begin
            prev_weight = w;
            first_char = 1'b0;
        end
        if (w > prev_weight)
        begin
            total_add(-run_acc);
            run_acc = 0;
        end
        else if (w < prev_weight)
        begin
            total_add(run_acc);
            run_acc = 0;
        end
        run_acc += w;
        if (run_acc > RUN_HI)
            run_acc = RUN_HI;
        prev_weight = w;
        if (!eon)
            return;

        total_add(run_acc);
        value = total_acc;
        clamp = 1'b0;
        if (value < 0)
        begin
            value = 0;
            clamp = 1'b1;
        end
        else if (value > MAX_VALUE)
        begin
            value = MAX_VALUE;
            clamp = 1'b1;
        end

        if (value == 0)
        begin
            item = '{SYM_NONE, 1'b1, 1'b1, saw_bad, clamp};
            minimal_letters.push_back(item);
        end
        else
        begin
            spell_minimal(value);
            foreach (spelled[i])
            begin
                item = '{spelled[i], i == spelled.size() - 1, 1'b0, saw_bad, clamp};
                minimal_letters.push_back(item);
            end
        end

        total_acc = 0;
        run_acc = 0;
        prev_weight = 0;
        first_char = 1'b1;
        saw_bad = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch on %0s: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
    endtask

    // send one character, in bursts with random gaps between them
    task automatic send_char(input logic [SYM_W-1:0] sym, input logic eon);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        symbol <= sym;
        end_of_numeral <= eon;
        do
            @(posedge clk);
        while (!in_ready);
        chars_sent++;
        parse_char(sym, eon);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // short numerals: cases, subtractive pairs, bad characters, zero and negative values
    task automatic test_directed_numerals();
        send_text("i");
        send_text("mCmXcIv");
        send_text("IIV");
        send_text("?");
        send_char(8'h00, 1'b1);
        send_char(SYM_X, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("DDDM");
        send_text("LLC");
        send_text("Ca");
    endtask

    // largest value in range and just above it
    task automatic test_value_limits();
        send_text("MMMMMMMMMCMXCIX");
        send_text("mmmmmmmmmm");
    endtask

    // run saturation on a long run of M
    task automatic test_long_runs();
        repeat (69) send_char(SYM_M, 1'b0);
        send_char(SYM_M, 1'b1);
    endtask

    // mostly well-formed numerals with random case, some letter soup and raw bytes
    task automatic test_random_numerals(input int n_chars);
        logic [SYM_W-1:0] word[$];
        int               target;
        int               kind;
        int               len;
        target = chars_sent + n_chars;
        while (chars_sent < target)
        begin
            word.delete();
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                if ($urandom_range(0, 3) == 0)
                    spell_minimal($urandom_range(1, MAX_VALUE));
                else
                    spell_minimal($urandom_range(1, 399));
                word = spelled;
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, 8);
                repeat (len) word.push_back(roman_set[$urandom_range(0, 6)]);
            end
            else
            begin
                len = $urandom_range(1, 5);
                repeat (len) word.push_back(SYM_W'($urandom_range(0, 255)));
            end

            // random case on letters
            foreach (word[i])
            begin
                if (word[i] >= "A" && word[i] <= "Z" && $urandom_range(0, 1) == 1)
                    word[i] = word[i] + CASE_OFFSET;
            end
            // stray byte now and then
            if (kind < 85 && $urandom_range(0, 9) == 0)
                word.insert($urandom_range(0, word.size()), SYM_W'($urandom_range(0, 255)));

            foreach (word[i])
                send_char(word[i], i == word.size() - 1);
        end
    endtask

    // receiver readiness in four modes, one of them never stalling, each picked at random for a phase of random length
    always @(negedge clk)
    begin
        if (ready_phase_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_phase_left = $urandom_range(20, 120);
        end
        ready_phase_left--;
        ready_tick++;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (ready_tick % 5 != 0);
        endcase
    end

    // compare each emitted letter with the oldest one predicted
    always @(posedge clk)
    begin
        letter_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (minimal_letters.size() == 0)
            begin
                report_mismatch("unexpected letter", out_symbol, 0);
            end
            else
            begin
                want = minimal_letters.pop_front();
                if (!want.empty && out_symbol !== want.sym)
                    report_mismatch("out_symbol", out_symbol, want.sym);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", is_empty, want.empty);
                if (bad_char !== want.bad)
                    report_mismatch("bad_char", bad_char, want.bad);
                if (clamped !== want.clamp)
                    report_mismatch("clamped", clamped, want.clamp);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("roman_numeral_minimizer_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        total_acc = 0;
        run_acc = 0;
        prev_weight = 0;
        first_char = 1'b1;
        saw_bad = 1'b0;
        mismatches = 0;
        chars_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        ready_mode = 0;
        ready_phase_left = 0;
        ready_tick = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_numerals();
        test_value_limits();
        test_long_runs();
        test_random_numerals(210);

        @(negedge clk);
        in_valid <= 1'b0;
        while (minimal_letters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("roman_numeral_minimizer_tb: PASS");
        else
            $display("roman_numeral_minimizer_tb: FAIL");
        $finish;
    end

endmodule
